/* sv/mrt_pkg.sv */
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared types and codes for the outstanding memory request table.
// ----------------------------------------------------------------------------
package mrt_pkg;

  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_TICK     = 3'd1;
  localparam logic [2:0] OP_ISSUE    = 3'd2;
  localparam logic [2:0] OP_COMPLETE = 3'd3;
  localparam logic [2:0] OP_DRAIN    = 3'd4;

  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_ISSUE  = 2'd1;
  localparam logic [1:0] KIND_RETURN = 2'd2;

  // results per issue or drain operation
  localparam int MAX_RESULTS = 16;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] address;
    logic        write_flag;
    logic [4:0]  accept_budget;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        success;
    logic [3:0]  slot;
    logic [31:0] out_address;
    logic        out_write;
    logic [31:0] issued_total;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic tick;
    logic rd_en;
    logic use_ptr;
    logic add_write;
    logic ack_emit;
    logic ack_ok;
    logic issue_emit;
    logic drain_emit;
    logic complete_set;
    logic ptr_set;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic free;
    logic eligible;
    logic match;
    logic drainable;
    logic out_free;
    logic pend_valid;
  } sts_t;

endpackage

/* sv/memory_request_table.sv */
// ----------------------------------------------------------------------------
// memory_request_table
// Outstanding memory request table with round-robin issue.
// ----------------------------------------------------------------------------
// A tick transaction moves every nonzero countdown down by one at once. Add,
// complete, issue and drain walk the table one entry at a time (entry memory
// read, then evaluation); add and complete stop at the first hit. The read
// port of the address memory sets the pace of the walk. An add, issue or
// drain waits while the result register is full and stalled. Results of an
// issue or drain leave through a one-deep staging register, so the final
// result carries its last flag. The request side is stalled while an
// operation is in progress; the configuration port is always ready and is
// meant to be written while the table is idle.
module memory_request_table #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mrt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mrt_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_data
);

  localparam int IW = $clog2(DEPTH);

  mrt_pkg::cmd_t cmd;
  mrt_pkg::sts_t sts;
  logic [IW-1:0] step;

  assign cfg_ready = 1'b1;

  mrt_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .op            (req.op),
    .accept_budget (req.accept_budget),
    .sts           (sts),
    .cmd           (cmd),
    .step          (step)
  );

  mrt_datapath #(.DEPTH(DEPTH)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .address    (req.address),
    .write_flag (req.write_flag),
    .cmd        (cmd),
    .step       (step),
    .sts        (sts),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

`ifndef SYNTHESIS
  // a new result must never overwrite a staged one that cannot move on
  a_push_no_loss: assert property (@(posedge clk) disable iff (rst)
    ((cmd.issue_emit || cmd.drain_emit) && sts.pend_valid) |-> sts.out_free)
    else $error("staged result overwritten");

  a_ack_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.ack_emit |-> (sts.out_free && !sts.pend_valid))
    else $error("add acknowledge with result register busy");

  a_flush_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> (sts.pend_valid && sts.out_free))
    else $error("flush without a staged result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(req_stall) |-> $past(req_valid))
    else $error("request side stalled without a transaction");
`endif

endmodule

/* sv/mrt_datapath.sv */
// ----------------------------------------------------------------------------
// mrt_datapath
// Entry storage, issue pointer, access counter and result registers.
// ----------------------------------------------------------------------------
module mrt_datapath #(
  parameter int DEPTH = 16,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         address,
  input  logic                write_flag,
  input  mrt_pkg::cmd_t       cmd,
  input  logic [IW-1:0]       step,
  output mrt_pkg::sts_t       sts,
  input  logic                cfg_valid,
  input  logic [7:0]          cfg_data,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output mrt_pkg::rsp_t       rsp
);

  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] ready;
  logic [DEPTH-1:0] inflight;
  logic [7:0]       countdown [DEPTH];
  logic [DEPTH-1:0] cd_zero;
  logic [32:0]      mem [DEPTH];
  logic [32:0]      rdata;
  logic [IW-1:0]    pointer;
  logic [31:0]      access_count;
  logic [7:0]       latency;
  logic [31:0]      item_addr;
  logic             item_wr;
  mrt_pkg::rsp_t    pend;
  logic             pend_valid;

  logic [IW:0]      ptr_sum;
  logic [IW-1:0]    idx;
  logic             emit;
  mrt_pkg::rsp_t    new_rsp;
  mrt_pkg::rsp_t    ack_rsp;
  mrt_pkg::rsp_t    flush_rsp;

  // issue walks from the pointer, everything else from entry zero
  always_comb begin
    ptr_sum = {1'b0, pointer} + {1'b0, step};
    if (ptr_sum >= (IW+1)'(DEPTH)) begin
      ptr_sum = ptr_sum - (IW+1)'(DEPTH);
    end
    idx = cmd.use_ptr ? ptr_sum[IW-1:0] : step;
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cd_zero[i] = (countdown[i] == 8'd0);
    end
  end

  assign sts.free       = !valid[idx];
  assign sts.eligible   = valid[idx] && !inflight[idx] && !ready[idx] && cd_zero[idx];
  assign sts.match      = valid[idx] && !ready[idx] && (rdata == {item_addr, item_wr});
  assign sts.drainable  = valid[idx] && ready[idx];
  assign sts.out_free   = !rsp_valid || !rsp_stall;
  assign sts.pend_valid = pend_valid;

  assign emit = cmd.issue_emit || cmd.drain_emit;

  always_comb begin
    new_rsp.kind         = cmd.issue_emit ? mrt_pkg::KIND_ISSUE : mrt_pkg::KIND_RETURN;
    new_rsp.success      = 1'b0;
    new_rsp.slot         = 4'(idx);
    new_rsp.out_address  = rdata[32:1];
    new_rsp.out_write    = rdata[0];
    new_rsp.issued_total = cmd.issue_emit ? access_count + 32'd1 : access_count;
    new_rsp.last         = 1'b0;

    ack_rsp.kind         = mrt_pkg::KIND_ACK;
    ack_rsp.success      = cmd.ack_ok;
    ack_rsp.slot         = cmd.ack_ok ? 4'(idx) : 4'd0;
    ack_rsp.out_address  = 32'd0;
    ack_rsp.out_write    = 1'b0;
    ack_rsp.issued_total = access_count;
    ack_rsp.last         = 1'b1;

    flush_rsp            = pend;
    flush_rsp.last       = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      ready    <= '0;
      inflight <= '0;
    end else begin
      if (cmd.add_write) begin
        valid[idx]    <= 1'b1;
        ready[idx]    <= 1'b0;
        inflight[idx] <= 1'b0;
      end
      if (cmd.issue_emit) begin
        inflight[idx] <= 1'b1;
      end
      if (cmd.complete_set) begin
        ready[idx]    <= 1'b1;
        inflight[idx] <= 1'b0;
      end
      if (cmd.drain_emit) begin
        valid[idx]    <= 1'b0;
        ready[idx]    <= 1'b0;
        inflight[idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (rst) begin
        countdown[i] <= 8'd0;
      end else if (cmd.tick && !cd_zero[i]) begin
        countdown[i] <= countdown[i] - 8'd1;
      end else if (cmd.add_write && idx == IW'(i)) begin
        countdown[i] <= latency;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_write) begin
      mem[idx] <= {item_addr, item_wr};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer      <= '0;
      access_count <= 32'd0;
      latency      <= 8'd1;
    end else begin
      if (cmd.ptr_set) begin
        pointer <= idx;
      end
      if (cmd.issue_emit) begin
        access_count <= access_count + 32'd1;
      end
      if (cfg_valid) begin
        latency <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_addr <= address;
      item_wr   <= write_flag;
    end
  end

  // a result waits in pend until the next one or the end of the walk sets last
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.ack_emit || (emit && pend_valid) || cmd.flush) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (emit) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ack_emit) begin
      rsp <= ack_rsp;
    end else if (emit && pend_valid) begin
      rsp <= pend;
    end else if (cmd.flush) begin
      rsp <= flush_rsp;
    end
    if (emit) begin
      pend <= new_rsp;
    end
  end

endmodule

/* sv/mrt_ctrl.sv */
// ----------------------------------------------------------------------------
// mrt_ctrl
// Sequencer that walks the table one entry per read/evaluate pair.
// ----------------------------------------------------------------------------
module mrt_ctrl #(
  parameter int DEPTH = 16,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  logic [2:0]    op,
  input  logic [4:0]    accept_budget,
  input  mrt_pkg::sts_t sts,
  output mrt_pkg::cmd_t cmd,
  output logic [IW-1:0] step
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_EVAL  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic [2:0]    op_q, op_q_next;
  logic [IW-1:0] step_next;
  logic [4:0]    budget, budget_next;
  logic [4:0]    dcount, dcount_next;
  logic          last_step;
  logic          can_push;
  logic          adv;
  logic          fin;

  assign last_step = (step == IW'(DEPTH - 1));
  assign can_push  = !sts.pend_valid || sts.out_free;
  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next  = state;
    op_q_next   = op_q;
    step_next   = step;
    budget_next = budget;
    dcount_next = dcount;
    cmd         = '0;
    cmd.use_ptr = (op_q == mrt_pkg::OP_ISSUE);
    adv         = 1'b0;
    fin         = 1'b0;

    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          op_q_next   = op;
          step_next   = '0;
          dcount_next = 5'd0;
          budget_next = (accept_budget > 5'(mrt_pkg::MAX_RESULTS)) ?
                        5'(mrt_pkg::MAX_RESULTS) : accept_budget;
          case (op)
            mrt_pkg::OP_ADD, mrt_pkg::OP_ISSUE,
            mrt_pkg::OP_COMPLETE, mrt_pkg::OP_DRAIN: begin
              state_next = ST_READ;
            end
            mrt_pkg::OP_TICK: begin
              cmd.tick = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_EVAL;
      end

      ST_EVAL: begin
        case (op_q)
          mrt_pkg::OP_ADD: begin
            if (sts.free) begin
              if (sts.out_free) begin
                cmd.add_write = 1'b1;
                cmd.ack_emit  = 1'b1;
                cmd.ack_ok    = 1'b1;
                state_next    = ST_IDLE;
              end
            end else if (last_step) begin
              if (sts.out_free) begin
                cmd.ack_emit = 1'b1;
                state_next   = ST_IDLE;
              end
            end else begin
              adv = 1'b1;
            end
          end
          mrt_pkg::OP_ISSUE: begin
            if (sts.eligible) begin
              if (budget == 5'd0) begin
                // pointer rests on the first refused entry
                cmd.ptr_set = 1'b1;
                fin         = 1'b1;
              end else if (can_push) begin
                cmd.issue_emit = 1'b1;
                budget_next    = budget - 5'd1;
                adv            = 1'b1;
              end
            end else begin
              adv = 1'b1;
            end
          end
          mrt_pkg::OP_COMPLETE: begin
            if (sts.match) begin
              cmd.complete_set = 1'b1;
              state_next       = ST_IDLE;
            end else if (last_step) begin
              state_next = ST_IDLE;
            end else begin
              adv = 1'b1;
            end
          end
          mrt_pkg::OP_DRAIN: begin
            if (sts.drainable) begin
              if (can_push) begin
                cmd.drain_emit = 1'b1;
                dcount_next    = dcount + 5'd1;
                if (dcount == 5'(mrt_pkg::MAX_RESULTS - 1)) begin
                  fin = 1'b1;
                end else begin
                  adv = 1'b1;
                end
              end
            end else begin
              adv = 1'b1;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase

        if (fin) begin
          state_next = ST_FLUSH;
        end else if (adv) begin
          if (last_step) begin
            state_next = ST_FLUSH;
          end else begin
            step_next  = step + IW'(1);
            state_next = ST_READ;
          end
        end
      end

      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      op_q   <= mrt_pkg::OP_TICK;
      step   <= '0;
      budget <= 5'd0;
      dcount <= 5'd0;
    end else begin
      state  <= state_next;
      op_q   <= op_q_next;
      step   <= step_next;
      budget <= budget_next;
      dcount <= dcount_next;
    end
  end

endmodule
